/* src/adcg_pkg.sv */
package adcg_pkg;

    typedef struct packed {
        logic [3:0] mode;
        logic [2:0] cal_kind;
        logic [3:0] reg_addr;
        logic [4:0] reg_count;
        logic       last_frame;
        logic [3:0] pos_input;
        logic [3:0] neg_input;
    } request_t;

    typedef struct packed {
        logic       accepted;
        logic [4:0] action;
        logic [7:0] opcode_byte;
        logic [7:0] count_byte;
        logic [7:0] mux_byte;
        logic [1:0] link_state;
        logic       data_ready;
    } result_t;

    typedef enum logic [1:0] {
        LINK_SLEEP = 2'd0,
        LINK_DRDY  = 2'd1,
        LINK_IDLE  = 2'd2,
        LINK_CONT  = 2'd3
    } link_t;

    localparam logic [3:0] MODE_READY     = 4'd0;
    localparam logic [3:0] MODE_WAKE      = 4'd1;
    localparam logic [3:0] MODE_CAL       = 4'd2;
    localparam logic [3:0] MODE_SYNC_WAKE = 4'd3;
    localparam logic [3:0] MODE_STANDBY   = 4'd4;
    localparam logic [3:0] MODE_RDREG     = 4'd5;
    localparam logic [3:0] MODE_WRREG     = 4'd6;
    localparam logic [3:0] MODE_RDDATA    = 4'd7;
    localparam logic [3:0] MODE_START     = 4'd8;
    localparam logic [3:0] MODE_FRAME     = 4'd9;
    localparam logic [3:0] MODE_STOP      = 4'd10;
    localparam logic [3:0] MODE_RESET     = 4'd11;
    localparam logic [3:0] MODE_MUX       = 4'd12;

    localparam logic [4:0] ACT_NONE      = 5'd0;
    localparam logic [4:0] ACT_WAKE      = 5'd1;
    localparam logic [4:0] ACT_CAL_SELF  = 5'd2;
    localparam logic [4:0] ACT_SYNC_WAKE = 5'd7;
    localparam logic [4:0] ACT_STANDBY   = 5'd8;
    localparam logic [4:0] ACT_RDREG     = 5'd9;
    localparam logic [4:0] ACT_WRREG     = 5'd10;
    localparam logic [4:0] ACT_RDDATA    = 5'd11;
    localparam logic [4:0] ACT_START     = 5'd12;
    localparam logic [4:0] ACT_FRAME     = 5'd13;
    localparam logic [4:0] ACT_STOP      = 5'd14;
    localparam logic [4:0] ACT_RESET     = 5'd15;
    localparam logic [4:0] ACT_MUX       = 5'd16;

    localparam logic [2:0] CAL_LAST      = 3'd4;
    localparam logic [5:0] LAST_REG      = 6'd10;
    localparam logic [3:0] MUX_REG_ADDR  = 4'd1;
    localparam logic [3:0] MAX_INPUT     = 4'd8;
    localparam logic [7:0] OP_RDREG      = 8'h10;
    localparam logic [7:0] OP_WRREG      = 8'h50;

endpackage

/* src/adc_command_state_guard.sv */
// Command guard for a delta-sigma converter's serial link.
// The request channel (request_valid, request_ready, request) carries one host
// request per word: a ready event or one of the link commands with its arguments.
// The result channel (result_valid, result_ready, result) returns one word per
// request: whether it was accepted, the command issued, the register opcode,
// count and multiplexer bytes, and the link state and data-ready flag after it.
// A request passes an input register and then a result register; its result
// is shown once it has been loaded into the result register.
// One request is taken every cycle unless the receiver stalls; the link state
// is updated as a request moves from the input register to the result register,
// so each request sees the state left by the one before it.
// Reset puts the link in the wait-for-data-ready state with the flag clear and
// empties both registers.
// When the receiver stalls, the result word holds and the input register keeps
// its request; request_ready drops once both are full and returns as soon as
// the result word is taken.
module adc_command_state_guard
    import adcg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     request_valid,
    output logic     request_ready,
    input  request_t request,
    output logic     result_valid,
    input  logic     result_ready,
    output result_t  result
);

    logic     stage_valid_reg;
    request_t stage_reg;
    logic     result_valid_reg;
    result_t  result_reg;
    link_t    link_reg;
    logic     flag_reg;

    link_t    link_next;
    logic     flag_next;
    result_t  result_next;
    logic     advance;
    logic     cmd_ready;
    logic     range_ok;
    logic     mux_ok;
    logic [5:0] reg_end;

    assign advance       = !result_valid_reg || result_ready;
    assign request_ready = !stage_valid_reg || advance;
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;

    assign cmd_ready = (link_reg == LINK_DRDY && flag_reg) || link_reg == LINK_IDLE;
    assign reg_end   = {2'b00, stage_reg.reg_addr} + {1'b0, stage_reg.reg_count};
    assign range_ok  = stage_reg.reg_count != 5'd0 && reg_end <= LAST_REG + 6'd1;
    assign mux_ok    = stage_reg.pos_input <= MAX_INPUT && stage_reg.neg_input <= MAX_INPUT
                       && stage_reg.pos_input != stage_reg.neg_input
                       && {2'b00, MUX_REG_ADDR} <= LAST_REG;

    always_comb
    begin
        link_next   = link_reg;
        flag_next   = flag_reg;
        result_next = '0;
        case (stage_reg.mode)
            MODE_READY:
            begin
                flag_next            = 1'b1;
                result_next.accepted = 1'b1;
            end
            MODE_WAKE:
            begin
                if (link_reg == LINK_SLEEP)
                begin
                    result_next.accepted = 1'b1;
                    result_next.action   = ACT_WAKE;
                    flag_next            = 1'b0;
                    link_next            = LINK_DRDY;
                end
            end
            MODE_CAL:
            begin
                if (stage_reg.cal_kind <= CAL_LAST && cmd_ready)
                begin
                    result_next.accepted = 1'b1;
                    result_next.action   = ACT_CAL_SELF + 5'(stage_reg.cal_kind);
                    flag_next            = 1'b0;
                    link_next            = LINK_DRDY;
                end
            end
            MODE_SYNC_WAKE:
            begin
                if (cmd_ready)
                begin
                    result_next.accepted = 1'b1;
                    result_next.action   = ACT_SYNC_WAKE;
                    flag_next            = 1'b0;
                    link_next            = LINK_DRDY;
                end
            end
            MODE_STANDBY:
            begin
                if (cmd_ready)
                begin
                    result_next.accepted = 1'b1;
                    result_next.action   = ACT_STANDBY;
                    link_next            = LINK_SLEEP;
                end
            end
            MODE_RDREG, MODE_WRREG:
            begin
                if (range_ok && cmd_ready)
                begin
                    result_next.accepted    = 1'b1;
                    result_next.action      = (stage_reg.mode == MODE_RDREG) ?
                                              ACT_RDREG : ACT_WRREG;
                    result_next.opcode_byte = {4'h0, stage_reg.reg_addr} |
                                              ((stage_reg.mode == MODE_RDREG) ?
                                               OP_RDREG : OP_WRREG);
                    result_next.count_byte  = {3'b000, stage_reg.reg_count - 5'd1};
                end
            end
            MODE_RDDATA:
            begin
                if (link_reg == LINK_DRDY && flag_reg)
                begin
                    result_next.accepted = 1'b1;
                    result_next.action   = ACT_RDDATA;
                    link_next            = LINK_IDLE;
                end
            end
            MODE_START:
            begin
                if (link_reg == LINK_DRDY && flag_reg)
                begin
                    result_next.accepted = 1'b1;
                    result_next.action   = ACT_START;
                    flag_next            = 1'b0;
                    link_next            = LINK_CONT;
                end
            end
            MODE_FRAME:
            begin
                if (link_reg == LINK_CONT && flag_reg)
                begin
                    result_next.accepted = 1'b1;
                    result_next.action   = ACT_FRAME;
                    flag_next            = 1'b0;
                    if (stage_reg.last_frame)
                    begin
                        link_next = LINK_IDLE;
                    end
                end
            end
            MODE_STOP:
            begin
                if (link_reg == LINK_CONT)
                begin
                    result_next.accepted = 1'b1;
                    result_next.action   = ACT_STOP;
                    link_next            = LINK_IDLE;
                end
            end
            MODE_RESET:
            begin
                result_next.accepted = 1'b1;
                result_next.action   = ACT_RESET;
                flag_next            = 1'b0;
                link_next            = LINK_DRDY;
            end
            MODE_MUX:
            begin
                if (mux_ok && cmd_ready)
                begin
                    result_next.accepted    = 1'b1;
                    result_next.action      = ACT_MUX;
                    result_next.opcode_byte = {4'h0, MUX_REG_ADDR} | OP_WRREG;
                    result_next.mux_byte    = {stage_reg.pos_input, stage_reg.neg_input};
                end
            end
            default:
            begin
                result_next.accepted = 1'b0;
            end
        endcase
        result_next.link_state = link_next;
        result_next.data_ready = flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            link_reg         <= LINK_DRDY;
            flag_reg         <= 1'b0;
        end
        else
        begin
            if (request_ready)
            begin
                stage_valid_reg <= request_valid;
            end
            if (advance)
            begin
                result_valid_reg <= stage_valid_reg;
            end
            if (advance && stage_valid_reg)
            begin
                link_reg <= link_next;
                flag_reg <= flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (request_ready && request_valid)
        begin
            stage_reg <= request;
        end
        if (advance && stage_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // A rejected request issues nothing and carries no bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.accepted |->
            result.action == ACT_NONE && result.opcode_byte == 8'h00 &&
            result.count_byte == 8'h00 && result.mux_byte == 8'h00)
        else $error("rejected request produced a command");

    // Standby always leaves the link asleep.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.action == ACT_STANDBY |-> result.link_state == LINK_SLEEP)
        else $error("standby did not put the link to sleep");

    // A frame read consumes the data-ready flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.action == ACT_FRAME |-> !result.data_ready)
        else $error("frame read left data ready set");

    // With both registers full and the receiver stalled, no request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && result_valid && !result_ready |-> !request_ready)
        else $error("request taken while pipeline is full and stalled");

    // The shown link state follows the state register once a result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage_valid_reg |=> result.link_state == link_reg &&
            result.data_ready == flag_reg)
        else $error("result state differs from link state register");

endmodule

/* verif/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import adcg_pkg::*;

    localparam logic [3:0] MODE_UNUSED_LO = 4'd13;
    localparam logic [3:0] MODE_UNUSED_HI = 4'd15;
    localparam int TARGET_REQUESTS = 1050;
    localparam int HOLD_CYCLES = 80;
    localparam logic [3:0] CMD_MODES [7] = '{MODE_CAL, MODE_SYNC_WAKE, MODE_STANDBY,
                                             MODE_RDREG, MODE_WRREG, MODE_MUX, MODE_RDDATA};

    class guard_scoreboard;
        link_t   link_mode;
        bit      ready_flag;
        result_t expected_q[$];
        int      mismatches;
        int      requests_seen;
        int      results_seen;
        int      accepted_count;
        bit      action_seen [0:16];

        function new();
            link_mode = LINK_DRDY;
            ready_flag = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function result_t guard_request(request_t r);
            result_t o;
            bit      cmd_ok;
            bit      regs_ok;
            o = '0;
            cmd_ok = (link_mode == LINK_DRDY && ready_flag) || link_mode == LINK_IDLE;
            regs_ok = r.reg_count != 0 &&
                      int'(r.reg_addr) + int'(r.reg_count) - 1 <= int'(LAST_REG);
            case (r.mode)
                MODE_READY:
                begin
                    ready_flag = 1'b1;
                    o.accepted = 1'b1;
                end
                MODE_WAKE:
                begin
                    if (link_mode == LINK_SLEEP)
                    begin
                        o.accepted = 1'b1;
                        o.action = ACT_WAKE;
                        ready_flag = 1'b0;
                        link_mode = LINK_DRDY;
                    end
                end
                MODE_CAL:
                begin
                    if (r.cal_kind <= CAL_LAST && cmd_ok)
                    begin
                        o.accepted = 1'b1;
                        o.action = ACT_CAL_SELF + 5'(r.cal_kind);
                        ready_flag = 1'b0;
                        link_mode = LINK_DRDY;
                    end
                end
                MODE_SYNC_WAKE:
                begin
                    if (cmd_ok)
                    begin
                        o.accepted = 1'b1;
                        o.action = ACT_SYNC_WAKE;
                        ready_flag = 1'b0;
                        link_mode = LINK_DRDY;
                    end
                end
                MODE_STANDBY:
                begin
                    if (cmd_ok)
                    begin
                        o.accepted = 1'b1;
                        o.action = ACT_STANDBY;
                        link_mode = LINK_SLEEP;
                    end
                end
                MODE_RDREG, MODE_WRREG:
                begin
                    if (regs_ok && cmd_ok)
                    begin
                        o.accepted = 1'b1;
                        o.action = (r.mode == MODE_RDREG) ? ACT_RDREG : ACT_WRREG;
                        o.opcode_byte = {4'd0, r.reg_addr} |
                                        ((r.mode == MODE_RDREG) ? OP_RDREG : OP_WRREG);
                        o.count_byte = 8'(r.reg_count - 5'd1);
                    end
                end
                MODE_RDDATA:
                begin
                    if (link_mode == LINK_DRDY && ready_flag)
                    begin
                        o.accepted = 1'b1;
                        o.action = ACT_RDDATA;
                        link_mode = LINK_IDLE;
                    end
                end
                MODE_START:
                begin
                    if (link_mode == LINK_DRDY && ready_flag)
                    begin
                        o.accepted = 1'b1;
                        o.action = ACT_START;
                        ready_flag = 1'b0;
                        link_mode = LINK_CONT;
                    end
                end
                MODE_FRAME:
                begin
                    if (link_mode == LINK_CONT && ready_flag)
                    begin
                        o.accepted = 1'b1;
                        o.action = ACT_FRAME;
                        if (r.last_frame)
                        begin
                            link_mode = LINK_IDLE;
                        end
                        ready_flag = 1'b0;
                    end
                end
                MODE_STOP:
                begin
                    if (link_mode == LINK_CONT)
                    begin
                        o.accepted = 1'b1;
                        o.action = ACT_STOP;
                        link_mode = LINK_IDLE;
                    end
                end
                MODE_RESET:
                begin
                    o.accepted = 1'b1;
                    o.action = ACT_RESET;
                    link_mode = LINK_DRDY;
                    ready_flag = 1'b0;
                end
                MODE_MUX:
                begin
                    if (r.pos_input <= MAX_INPUT && r.neg_input <= MAX_INPUT &&
                        r.pos_input != r.neg_input && cmd_ok)
                    begin
                        o.accepted = 1'b1;
                        o.action = ACT_MUX;
                        o.opcode_byte = {4'd0, MUX_REG_ADDR} | OP_WRREG;
                        o.mux_byte = {r.pos_input, r.neg_input};
                    end
                end
                default:
                begin
                end
            endcase
            o.link_state = link_mode;
            o.data_ready = ready_flag;
            return o;
        endfunction

        function void note_request(request_t r);
            result_t want;
            want = guard_request(r);
            requests_seen++;
            if (want.accepted)
            begin
                accepted_count++;
                action_seen[want.action] = 1'b1;
            end
            expected_q.push_back(want);
        endfunction

        function void report(string field, logic [7:0] want, logic [7:0] got);
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result word with no request waiting, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            if (got.accepted !== want.accepted)
                report("accepted", 8'(want.accepted), 8'(got.accepted));
            if (got.action !== want.action)
                report("action", 8'(want.action), 8'(got.action));
            if (got.opcode_byte !== want.opcode_byte)
                report("opcode_byte", want.opcode_byte, got.opcode_byte);
            if (got.count_byte !== want.count_byte)
                report("count_byte", want.count_byte, got.count_byte);
            if (got.mux_byte !== want.mux_byte)
                report("mux_byte", want.mux_byte, got.mux_byte);
            if (got.link_state !== want.link_state)
                report("link_state", 8'(want.link_state), 8'(got.link_state));
            if (got.data_ready !== want.data_ready)
                report("data_ready", 8'(want.data_ready), 8'(got.data_ready));
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     request_valid;
    logic     request_ready;
    request_t request;
    logic     result_valid;
    logic     result_ready;
    result_t  result;

    guard_scoreboard board;
    bit sender_calm;
    bit sink_calm;
    bit long_hold;

    adc_command_state_guard u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .request_valid(request_valid),
        .request_ready(request_ready),
        .request      (request),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #10 clk = ~clk;

    function automatic request_t mk(logic [3:0] mode, logic [2:0] cal, logic [3:0] addr,
                                    logic [4:0] cnt, logic last, logic [3:0] pos,
                                    logic [3:0] neg);
        request_t r;
        r = '{mode, cal, addr, cnt, last, pos, neg};
        return r;
    endfunction

    function automatic request_t rand_args(logic [3:0] mode);
        request_t r;
        r.mode = mode;
        if ($urandom_range(0, 99) < 85)
            r.cal_kind = 3'($urandom_range(0, int'(CAL_LAST)));
        else
            r.cal_kind = 3'($urandom_range(0, 7));
        r.reg_addr = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 75 && int'(r.reg_addr) <= int'(LAST_REG))
            r.reg_count = 5'($urandom_range(1, int'(LAST_REG) + 1 - int'(r.reg_addr)));
        else
            r.reg_count = 5'($urandom_range(0, 31));
        r.last_frame = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 75)
        begin
            r.pos_input = 4'($urandom_range(0, int'(MAX_INPUT)));
            r.neg_input = 4'($urandom_range(0, int'(MAX_INPUT) - 1));
            if (r.neg_input >= r.pos_input)
                r.neg_input = r.neg_input + 4'd1;
        end
        else
        begin
            r.pos_input = 4'($urandom_range(0, 15));
            r.neg_input = 4'($urandom_range(0, 15));
        end
        return r;
    endfunction

    task automatic issue(request_t r);
        request_valid <= 1'b1;
        request <= r;
        @(posedge clk);
        while (!request_ready)
            @(posedge clk);
        board.note_request(r);
        if (!sender_calm && $urandom_range(0, 99) < 6)
        begin
            request_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic issue_mode(logic [3:0] mode);
        issue(rand_args(mode));
    endtask

    task automatic wait_drained();
        request_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_scenario();
        int       kind;
        int       frames;
        request_t r;
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            if ($urandom_range(0, 99) < 90)
                issue_mode(MODE_READY);
            issue_mode(MODE_START);
            frames = $urandom_range(1, 6);
            repeat (frames)
            begin
                if ($urandom_range(0, 99) < 90)
                    issue_mode(MODE_READY);
                r = rand_args(MODE_FRAME);
                r.last_frame = 1'b0;
                issue(r);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                issue_mode(MODE_READY);
                r = rand_args(MODE_FRAME);
                r.last_frame = 1'b1;
                issue(r);
            end
            else
            begin
                issue_mode(MODE_STOP);
            end
        end
        else if (kind < 65)
        begin
            if ($urandom_range(0, 99) < 80)
                issue_mode(MODE_READY);
            repeat ($urandom_range(1, 3))
                issue_mode(CMD_MODES[$urandom_range(0, 6)]);
            if ($urandom_range(0, 1) == 0)
                issue_mode(MODE_WAKE);
        end
        else if (kind < 80)
        begin
            issue_mode(MODE_RESET);
            if ($urandom_range(0, 99) < 70)
                issue_mode(MODE_READY);
        end
        else
        begin
            r = rand_args(4'($urandom_range(0, 15)));
            r.cal_kind = 3'($urandom_range(0, 7));
            r.reg_count = 5'($urandom_range(0, 31));
            issue(r);
        end
    endtask

    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                result_ready <= sink_calm || $urandom_range(0, 99) >= 6;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_result(result);
    end

    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int  n;
        int  distinct;
        bit  drain_done;
        bit  hold_done;
        board = new();
        rst_n = 1'b0;
        request_valid = 1'b0;
        request = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(mk(MODE_RDDATA, 3'd0, 4'd0, 5'd1, 1'b0, 4'd0, 4'd1));
        issue(mk(MODE_UNUSED_LO, 3'd0, 4'd0, 5'd1, 1'b0, 4'd0, 4'd1));
        issue(mk(MODE_UNUSED_HI, 3'd7, 4'd15, 5'd31, 1'b1, 4'd15, 4'd15));
        issue(mk(MODE_READY, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_RDREG, 3'd0, 4'd0, 5'd11, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_WRREG, 3'd0, 4'd10, 5'd1, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_RDREG, 3'd0, 4'd3, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_WRREG, 3'd0, 4'd15, 5'd16, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_RDREG, 3'd0, 4'd5, 5'd31, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_MUX, 3'd0, 4'd0, 5'd0, 1'b0, 4'd8, 4'd0));
        issue(mk(MODE_MUX, 3'd0, 4'd0, 5'd0, 1'b0, 4'd3, 4'd3));
        issue(mk(MODE_MUX, 3'd0, 4'd0, 5'd0, 1'b0, 4'd9, 4'd2));
        issue(mk(MODE_CAL, 3'd7, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_CAL, CAL_LAST, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_READY, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_START, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_FRAME, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_READY, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_FRAME, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_STOP, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_RDDATA, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_STANDBY, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_WAKE, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_READY, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_RDDATA, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_SYNC_WAKE, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        issue(mk(MODE_RESET, 3'd0, 4'd0, 5'd0, 1'b0, 4'd0, 4'd0));
        wait_drained();

        drain_done = 1'b0;
        hold_done = 1'b0;
        while (board.requests_seen < TARGET_REQUESTS)
        begin
            n = board.requests_seen;
            sender_calm = (n >= 200 && n < 400) || (n >= 650 && n < 760);
            sink_calm = n >= 200 && n < 400;
            if (!drain_done && n >= 500)
            begin
                wait_drained();
                drain_done = 1'b1;
            end
            if (!hold_done && n >= 680)
            begin
                long_hold = 1'b1;
                hold_done = 1'b1;
            end
            run_scenario();
        end

        request_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        distinct = 0;
        foreach (board.action_seen[i])
            distinct += board.action_seen[i];
        $display("Run covered %0d requests and %0d result words; %0d requests were accepted.",
                 board.requests_seen, board.results_seen, board.accepted_count);
        $display("Accepted requests issued %0d of 17 command codes; %0d mismatches.",
                 distinct, board.mismatches);
        if (board.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
